// ===== rtl/core/rbs_pkg.sv =====
// Shared types and constants for the ray/box slab test block.
`timescale 1ns / 1ps
`default_nettype none
package rbs_pkg;
   localparam int DEF_COORD_WIDTH = 32;
   localparam int DEF_FRAC_BITS   = 16;

   localparam logic [1:0] ACT_CLEAR     = 2'd0;
   localparam logic [1:0] ACT_ADD       = 2'd1;
   localparam logic [1:0] ACT_INTERSECT = 2'd2;

   typedef struct packed {
      logic clear;
      logic add;
      logic capture;
      logic load;
      logic step;
      logic fix;
      logic order;
      logic comb;
      logic span;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
   } status_type;
endpackage
`default_nettype wire

// ===== rtl/core/ray_box_slab_test.sv =====
// Top level of the ray versus axis-aligned box slab test.
// Clear and add items are handled in the idle state; the next item is taken in the next cycle.
// An intersect item is captured, loaded into the bit-per-cycle restoring dividers
// (six lanes, one per slab plane), stepped, then fixed, ordered, combined and spanned.
// The request side stalls until the intersect sequence is back in idle; a finished
// result may wait in the output register while the next item is taken.
// Synchronous active-high reset: empty box (low at max, high at min), no result pending.
`timescale 1ns / 1ps
`default_nettype none
module ray_box_slab_test #(
   parameter int COORD_WIDTH = rbs_pkg::DEF_COORD_WIDTH,
   parameter int FRAC_BITS   = rbs_pkg::DEF_FRAC_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [1:0]                    req_action,
   input  wire logic signed [COORD_WIDTH-1:0] req_pos_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_pos_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_pos_z,
   input  wire logic signed [COORD_WIDTH-1:0] req_dir_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_dir_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_dir_z,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic signed [COORD_WIDTH-1:0]      rsp_span
);
   import rbs_pkg::*;

   // command and status between the sequencer and the datapath
   cmd_type    cmd;
   status_type status;

   rbs_ctrl #(.COORD_WIDTH(COORD_WIDTH)) u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_action(req_action), .req_stall(req_stall),
      .status(status), .cmd(cmd));

   // box corners, divider lanes, entry/exit ordering and the output item register
   rbs_datapath #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .pos_x(req_pos_x), .pos_y(req_pos_y), .pos_z(req_pos_z),
      .dir_x(req_dir_x), .dir_y(req_dir_y), .dir_z(req_dir_z),
      .rsp_stall(rsp_stall), .rsp_valid(rsp_valid), .rsp_span(rsp_span));
endmodule
`default_nettype wire

// ===== rtl/core/rbs_div.sv =====
// Iterative restoring divider lane: (num << FRAC_BITS) / den, saturated.
`timescale 1ns / 1ps
`default_nettype none
module rbs_div #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  wire logic                          clock,
   input  wire logic                          load,
   input  wire logic                          step,
   input  wire logic signed [COORD_WIDTH:0]   num,
   input  wire logic signed [COORD_WIDTH-1:0] den,
   output logic signed [COORD_WIDTH-1:0]      quot
);
   localparam int W    = COORD_WIDTH;
   localparam int NW   = W + 1;
   localparam int DW   = W + 1 + FRAC_BITS;
   localparam int CMPW = (DW > 2 * W - 1) ? DW : 2 * W - 1;

   logic [NW-1:0]  rem_ff, rem_in;
   logic [W-2:0]   low_ff, low_in;
   logic [W-2:0]   q_ff, q_in;
   logic           neg_ff, neg_in, zero_ff, zero_in, sat_ff, sat_in, nsgn_ff, nsgn_in;

   logic [NW-1:0]  nm;
   logic [W-1:0]   dm;
   logic [DW-1:0]  dvd, dvd_hi;
   logic [CMPW-1:0] cmp_a, cmp_b;
   logic [NW-1:0]  trial;
   logic [NW-1:0]  dm_ext;

   always_comb begin
      nm      = num[W] ? NW'(-num) : NW'(num);
      dm      = den[W-1] ? W'(-den) : W'(den);
      dvd     = {nm, {FRAC_BITS{1'b0}}};
      dvd_hi  = dvd >> (W - 1);
      cmp_a   = CMPW'(dvd);
      cmp_b   = CMPW'({dm, {(W-1){1'b0}}});
      dm_ext  = NW'(dm);
      trial   = {rem_ff[NW-2:0], low_ff[W-2]};

      rem_in  = rem_ff;
      low_in  = low_ff;
      q_in    = q_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      sat_in  = sat_ff;
      nsgn_in = nsgn_ff;
      if (load) begin
         rem_in  = dvd_hi[NW-1:0];
         low_in  = dvd[W-2:0];
         q_in    = '0;
         neg_in  = num[W] ^ den[W-1];
         nsgn_in = num[W];
         zero_in = (den == '0);
         sat_in  = (cmp_a >= cmp_b);
      end else if (step) begin
         low_in = {low_ff[W-3:0], 1'b0};
         if (trial >= dm_ext) begin
            rem_in = trial - dm_ext;
            q_in   = {q_ff[W-3:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[W-3:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      q_ff    <= q_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      sat_ff  <= sat_in;
      nsgn_ff <= nsgn_in;
   end

   always_comb begin
      if (zero_ff)
         quot = nsgn_ff ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      else if (sat_ff)
         quot = neg_ff ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      else if (neg_ff)
         quot = -$signed({1'b0, q_ff});
      else
         quot = $signed({1'b0, q_ff});
   end
endmodule
`default_nettype wire

// ===== rtl/core/rbs_datapath.sv =====
// Datapath: box corners, six divider lanes, ordering and span output.
`timescale 1ns / 1ps
`default_nettype none
module rbs_datapath #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire rbs_pkg::cmd_type              cmd,
   output rbs_pkg::status_type                status,
   input  wire logic signed [COORD_WIDTH-1:0] pos_x,
   input  wire logic signed [COORD_WIDTH-1:0] pos_y,
   input  wire logic signed [COORD_WIDTH-1:0] pos_z,
   input  wire logic signed [COORD_WIDTH-1:0] dir_x,
   input  wire logic signed [COORD_WIDTH-1:0] dir_y,
   input  wire logic signed [COORD_WIDTH-1:0] dir_z,
   input  wire logic                          rsp_stall,
   output logic                               rsp_valid,
   output logic signed [COORD_WIDTH-1:0]      rsp_span
);
   import rbs_pkg::*;
   localparam int W = COORD_WIDTH;
   localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

   logic signed [W-1:0] low_ff [3], low_in [3];
   logic signed [W-1:0] high_ff [3], high_in [3];
   logic signed [W-1:0] pos_ff [3], pos_in [3];
   logic signed [W-1:0] dir_ff [3], dir_in [3];
   logic signed [W-1:0] pin [3], din [3];
   logic signed [W:0]   num_lo [3], num_hi [3];
   logic signed [W-1:0] q_lo [3], q_hi [3];
   logic signed [W-1:0] a_ff [3], a_in [3], b_ff [3], b_in [3];
   logic signed [W-1:0] s_ff [3], s_in [3], e_ff [3], e_in [3];
   logic signed [W-1:0] tin_ff, tin_in, tout_ff, tout_in;
   logic signed [W-1:0] m01, n01;
   logic signed [W:0]   diff;
   logic signed [W-1:0] span_ff, span_in;
   logic                valid_ff, valid_in;

   assign pin = '{pos_x, pos_y, pos_z};
   assign din = '{dir_x, dir_y, dir_z};

   for (genvar a = 0; a < 3; a++) begin : g_axis
      assign num_lo[a] = {low_ff[a][W-1], low_ff[a]} - {pos_ff[a][W-1], pos_ff[a]};
      assign num_hi[a] = {high_ff[a][W-1], high_ff[a]} - {pos_ff[a][W-1], pos_ff[a]};
      rbs_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_lo (
         .clock(clock), .load(cmd.load), .step(cmd.step),
         .num(num_lo[a]), .den(dir_ff[a]), .quot(q_lo[a]));
      rbs_div #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_hi (
         .clock(clock), .load(cmd.load), .step(cmd.step),
         .num(num_hi[a]), .den(dir_ff[a]), .quot(q_hi[a]));
   end

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         low_in[a]  = low_ff[a];
         high_in[a] = high_ff[a];
         pos_in[a]  = pos_ff[a];
         dir_in[a]  = dir_ff[a];
         a_in[a]    = a_ff[a];
         b_in[a]    = b_ff[a];
         s_in[a]    = s_ff[a];
         e_in[a]    = e_ff[a];
         if (cmd.clear) begin
            low_in[a]  = MAXV;
            high_in[a] = MINV;
         end
         if (cmd.add) begin
            if (pin[a] < low_ff[a])  low_in[a]  = pin[a];
            if (pin[a] > high_ff[a]) high_in[a] = pin[a];
         end
         if (cmd.capture) begin
            pos_in[a] = pin[a];
            dir_in[a] = din[a];
         end
         if (cmd.fix) begin
            a_in[a] = q_lo[a];
            b_in[a] = q_hi[a];
         end
         if (cmd.order) begin
            s_in[a] = (a_ff[a] > b_ff[a]) ? b_ff[a] : a_ff[a];
            e_in[a] = (a_ff[a] > b_ff[a]) ? a_ff[a] : b_ff[a];
         end
      end
   end

   always_comb begin
      m01     = (s_ff[1] > s_ff[0]) ? s_ff[1] : s_ff[0];
      n01     = (e_ff[1] < e_ff[0]) ? e_ff[1] : e_ff[0];
      tin_in  = tin_ff;
      tout_in = tout_ff;
      if (cmd.comb) begin
         tin_in  = (s_ff[2] > m01) ? s_ff[2] : m01;
         tout_in = (e_ff[2] < n01) ? e_ff[2] : n01;
      end
      diff    = {tout_ff[W-1], tout_ff} - {tin_ff[W-1], tin_ff};
      span_in = span_ff;
      if (cmd.span) begin
         if (diff > $signed({MAXV[W-1], MAXV}))      span_in = MAXV;
         else if (diff < $signed({MINV[W-1], MINV})) span_in = MINV;
         else                                        span_in = diff[W-1:0];
      end
      if (cmd.span)                 valid_in = 1'b1;
      else if (valid_ff && rsp_stall) valid_in = 1'b1;
      else                          valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            low_ff[a]  <= MAXV;
            high_ff[a] <= MINV;
         end
         valid_ff <= 1'b0;
      end else begin
         low_ff   <= low_in;
         high_ff  <= high_in;
         valid_ff <= valid_in;
      end
      pos_ff  <= pos_in;
      dir_ff  <= dir_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      s_ff    <= s_in;
      e_ff    <= e_in;
      tin_ff  <= tin_in;
      tout_ff <= tout_in;
      span_ff <= span_in;
   end

   assign status.out_busy = valid_ff && rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_span  = span_ff;
endmodule
`default_nettype wire

// ===== rtl/core/rbs_ctrl.sv =====
// Controller state machine: sequences capture, division and the span stages.
`timescale 1ns / 1ps
`default_nettype none
module rbs_ctrl #(
   parameter int COORD_WIDTH = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic [1:0]         req_action,
   output logic                    req_stall,
   input  wire rbs_pkg::status_type status,
   output rbs_pkg::cmd_type        cmd
);
   import rbs_pkg::*;
   localparam int CW = $clog2(COORD_WIDTH);
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LOAD  = 3'd1;
   localparam logic [2:0] S_STEP  = 3'd2;
   localparam logic [2:0] S_FIX   = 3'd3;
   localparam logic [2:0] S_ORDER = 3'd4;
   localparam logic [2:0] S_COMB  = 3'd5;
   localparam logic [2:0] S_SPAN  = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          take;

   assign req_stall = (state_ff != S_IDLE);
   assign take      = req_valid && (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (take) begin
               case (req_action)
                  ACT_CLEAR: cmd.clear = 1'b1;
                  ACT_ADD:   cmd.add = 1'b1;
                  ACT_INTERSECT: begin
                     cmd.capture = 1'b1;
                     state_in    = S_LOAD;
                  end
                  default: ;
               endcase
            end
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            cnt_in   = CW'(COORD_WIDTH - 2);
            state_in = S_STEP;
         end
         S_STEP: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff - 1'b1;
            if (cnt_ff == '0) state_in = S_FIX;
         end
         S_FIX: begin
            cmd.fix  = 1'b1;
            state_in = S_ORDER;
         end
         S_ORDER: begin
            cmd.order = 1'b1;
            state_in  = S_COMB;
         end
         S_COMB: begin
            cmd.comb = 1'b1;
            state_in = S_SPAN;
         end
         S_SPAN: begin
            if (!status.out_busy) begin
               cmd.span = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end
endmodule
`default_nettype wire
